### design/hkr_pkg.sv
// Shared constants, payload types and helpers for the keyboard report event block.
package hkr_pkg;

    localparam int KEY_SLOTS        = 6;
    localparam int INPUT_KEY_FIELDS = 6;
    localparam int ACTIVE_SLOTS     = (KEY_SLOTS < INPUT_KEY_FIELDS) ? KEY_SLOTS
                                                                     : INPUT_KEY_FIELDS;
    localparam int MOD_BITS         = 8;
    localparam int CODE_W           = 8;
    localparam int EVENT_COUNT      = 2 * ACTIVE_SLOTS + MOD_BITS;
    localparam int EVENT_IDX_W      = $clog2(EVENT_COUNT);

    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [MOD_BITS-1:0] mods_t;

    typedef struct packed {
        mods_t modifier_bits;
        code_t key_slot0;
        code_t key_slot1;
        code_t key_slot2;
        code_t key_slot3;
        code_t key_slot4;
        code_t key_slot5;
    } report_t;

    typedef struct packed {
        code_t code;
        logic  is_modifier;
        logic  pressed;
        logic  last_event;
    } key_event_t;

    typedef struct packed {
        logic capture;
        logic load_mask;
        logic emit;
        logic commit;
    } hkr_cmd_t;

    typedef struct packed {
        logic fresh_empty;
        logic pick_last;
        logic out_free;
    } hkr_status_t;

    function automatic logic usage_mapped(input code_t u);
        return ((u >= code_t'(4))   && (u <= code_t'(69)))  ||
               (u == code_t'(71))                           ||
               ((u >= code_t'(73))  && (u <= code_t'(103))) ||
               (u == code_t'(133))                          ||
               ((u >= code_t'(135)) && (u <= code_t'(140))) ||
               ((u >= code_t'(144)) && (u <= code_t'(148)));
    endfunction

endpackage

### design/hkr_if.sv
// Valid/ready channel interfaces for reports in and key events out.
interface hkr_report_if;
    import hkr_pkg::*;
    logic    valid;
    logic    ready;
    report_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hkr_event_if;
    import hkr_pkg::*;
    logic       valid;
    logic       ready;
    key_event_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/hkr_datapath.sv
// Datapath: report registers, event mask, event picker and output register.
module hkr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  hkr_pkg::report_t    in_data,
    input  hkr_pkg::hkr_cmd_t   cmd,
    output hkr_pkg::hkr_status_t status,
    hkr_event_if.source         key_event
);
    import hkr_pkg::*;

    code_t in_slot [INPUT_KEY_FIELDS];
    code_t cur_keys_reg [KEY_SLOTS];
    code_t prev_keys_reg [KEY_SLOTS];
    mods_t cur_mods_reg;
    mods_t prev_mods_reg;
    logic [EVENT_COUNT-1:0] pending_reg;
    logic [EVENT_COUNT-1:0] pending_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    key_event_t             out_data_reg;

    logic [ACTIVE_SLOTS-1:0] new_active;
    logic [ACTIVE_SLOTS-1:0] old_active;
    logic [ACTIVE_SLOTS-1:0] new_in_old;
    logic [ACTIVE_SLOTS-1:0] old_in_new;
    logic [EVENT_COUNT-1:0]  fresh_mask;
    code_t                   ev_code  [EVENT_COUNT];
    logic                    ev_mod   [EVENT_COUNT];
    logic                    ev_press [EVENT_COUNT];
    logic [EVENT_IDX_W-1:0]  pick_idx;
    logic [EVENT_COUNT-1:0]  pick_onehot;
    key_event_t              pick_event;

    assign in_slot[0] = in_data.key_slot0;
    assign in_slot[1] = in_data.key_slot1;
    assign in_slot[2] = in_data.key_slot2;
    assign in_slot[3] = in_data.key_slot3;
    assign in_slot[4] = in_data.key_slot4;
    assign in_slot[5] = in_data.key_slot5;

    // list prefixes up to the first zero
    always_comb
    begin
        for (int i = 0; i < ACTIVE_SLOTS; i++)
        begin
            if (i == 0)
            begin
                new_active[i] = (cur_keys_reg[i] != '0);
                old_active[i] = (prev_keys_reg[i] != '0);
            end
            else
            begin
                new_active[i] = new_active[i-1] && (cur_keys_reg[i] != '0);
                old_active[i] = old_active[i-1] && (prev_keys_reg[i] != '0);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ACTIVE_SLOTS; i++)
        begin
            new_in_old[i] = 1'b0;
            old_in_new[i] = 1'b0;
            for (int j = 0; j < ACTIVE_SLOTS; j++)
            begin
                new_in_old[i] = new_in_old[i] ||
                                (old_active[j] && (prev_keys_reg[j] == cur_keys_reg[i]));
                old_in_new[i] = old_in_new[i] ||
                                (new_active[j] && (cur_keys_reg[j] == prev_keys_reg[i]));
            end
        end
    end

    // event slots: presses, then releases, then modifier bits
    always_comb
    begin
        for (int i = 0; i < ACTIVE_SLOTS; i++)
        begin
            ev_code[i]    = cur_keys_reg[i];
            ev_mod[i]     = 1'b0;
            ev_press[i]   = 1'b1;
            fresh_mask[i] = new_active[i] && !new_in_old[i] && usage_mapped(cur_keys_reg[i]);
            ev_code[ACTIVE_SLOTS + i]    = prev_keys_reg[i];
            ev_mod[ACTIVE_SLOTS + i]     = 1'b0;
            ev_press[ACTIVE_SLOTS + i]   = 1'b0;
            fresh_mask[ACTIVE_SLOTS + i] = old_active[i] && !old_in_new[i] &&
                                           usage_mapped(prev_keys_reg[i]);
        end
        for (int b = 0; b < MOD_BITS; b++)
        begin
            ev_code[2*ACTIVE_SLOTS + b]    = CODE_W'(b);
            ev_mod[2*ACTIVE_SLOTS + b]     = 1'b1;
            ev_press[2*ACTIVE_SLOTS + b]   = cur_mods_reg[b];
            fresh_mask[2*ACTIVE_SLOTS + b] = cur_mods_reg[b] ^ prev_mods_reg[b];
        end
    end

    always_comb
    begin
        pick_idx = '0;
        for (int e = EVENT_COUNT - 1; e >= 0; e--)
        begin
            if (pending_reg[e])
            begin
                pick_idx = EVENT_IDX_W'(e);
            end
        end
        pick_onehot = '0;
        pick_onehot[pick_idx] = 1'b1;
        pick_event.code        = ev_code[pick_idx];
        pick_event.is_modifier = ev_mod[pick_idx];
        pick_event.pressed     = ev_press[pick_idx];
        pick_event.last_event  = ((pending_reg & ~pick_onehot) == '0);
    end

    assign status.fresh_empty = (fresh_mask == '0);
    assign status.pick_last   = pick_event.last_event;
    assign status.out_free    = !out_valid_reg || key_event.ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd.load_mask)
        begin
            pending_next = fresh_mask;
        end
        else if (cmd.emit)
        begin
            pending_next = pending_reg & ~pick_onehot;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (key_event.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                if (i < ACTIVE_SLOTS)
                begin
                    cur_keys_reg[i] <= in_slot[i];
                end
                else
                begin
                    cur_keys_reg[i] <= '0;
                end
            end
            cur_mods_reg <= in_data.modifier_bits;
        end
        if (cmd.emit)
        begin
            out_data_reg <= pick_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_keys_reg[i] <= '0;
            end
            prev_mods_reg <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                prev_keys_reg <= cur_keys_reg;
                prev_mods_reg <= cur_mods_reg;
            end
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign key_event.valid = out_valid_reg;
    assign key_event.data  = out_data_reg;

endmodule

### design/hkr_controller.sv
// Controller: sequences capture, compare and event emission for one report.
module hkr_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output hkr_pkg::hkr_cmd_t    cmd,
    input  hkr_pkg::hkr_status_t status
);
    import hkr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_mask = 1'b1;
                if (status.fresh_empty)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.pick_last)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/hid_keyboard_report_to_key_events.sv
// Top level: boot keyboard report in, key press/release events out.
//
// report: one boot keyboard report per item (modifier byte, six key usages).
// key_event: one press or release per item; last_event marks the final event
//   of a report. A report equal to the previous one gives no events.
// Order: new-key presses in slot order, old-key releases in slot order,
//   then modifier changes for bits 0 to 7.
// Sequence: the report is captured, its event mask is loaded, then its events
//   (0 to 20) leave one event per cycle from the picker over the registered
//   event mask while key_event does not stall; a stall on key_event holds
//   the picker.
// report.ready is high only while no report is in work; it rises again in
//   the cycle after the last event is loaded into the output register, so
//   a new report may be taken while that event still waits.
// A stalled key_event holds its item in the output register.
// Reset clears the previous report to all-zero keys and modifiers.
module hid_keyboard_report_to_key_events (
    input  logic        clk,
    input  logic        rst_n,
    hkr_report_if.sink  report,
    hkr_event_if.source key_event
);
    import hkr_pkg::*;

    hkr_cmd_t    cmd;
    hkr_status_t status;

    hkr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (report.valid),
        .in_ready (report.ready),
        .cmd      (cmd),
        .status   (status)
    );

    hkr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (report.data),
        .cmd       (cmd),
        .status    (status),
        .key_event (key_event)
    );

endmodule

### design/hkr_checker.sv
// Port-level checks for the keyboard report event block, bound to the top level.
module hkr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input hkr_pkg::key_event_t out_data
);
    import hkr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled event item dropped or changed");

    a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("report taken while previous still in work");

    a_busy_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_event |-> !in_ready)
        else $error("report channel open before last event");

    a_events_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_event |=> out_valid)
        else $error("gap after non-final event");

endmodule

bind hid_keyboard_report_to_key_events hkr_checker u_hkr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (report.valid),
    .in_ready  (report.ready),
    .out_valid (key_event.valid),
    .out_ready (key_event.ready),
    .out_data  (key_event.data)
);
